>>> rtl/qte_pkg.sv
// Package for the quaternion to XYZ Euler angle core.
// Holds datapath widths, stage counts, angle constants and the CORDIC arctangent table.
// No dependencies.
package qte_pkg;

  // Stage counts
  localparam int DIV_STEPS    = 31;
  localparam int SQRT_STEPS   = 31;
  localparam int CORDIC_STEPS = 20;
  localparam int NUM_ENT      = 7;
  localparam int NUM_LANES    = 3;

  // Total latency from accepted item to done strobe:
  // products, numerators, divider load, divider steps, sign apply, squares,
  // root load, root steps, CORDIC load, CORDIC steps, output register
  localparam int LATENCY = 2 + 1 + DIV_STEPS + 1 + 1 + 1 + SQRT_STEPS + 1 + CORDIC_STEPS + 1;

  // Widths
  localparam int PRD_W = 32;  // 16x16 products
  localparam int NUM_W = 35;  // matrix numerators, signed
  localparam int DEN_W = 33;  // squared norm, unsigned
  localparam int REM_W = 35;  // divider remainder
  localparam int Q_W   = 31;  // divider quotient
  localparam int ENT_W = 32;  // matrix entry, signed Q2.30
  localparam int RAD_W = 63;  // radicand and root work registers
  localparam int CY_W  = 31;  // cosine term
  localparam int XY_W  = 34;  // CORDIC vector, signed
  localparam int ACC_W = 27;  // angle accumulator, 2^-16 degree units
  localparam int ANG_W = 16;  // output angle, Q9.7

  // Matrix entry positions
  localparam int E00 = 0;
  localparam int E10 = 1;
  localparam int E11 = 2;
  localparam int E12 = 3;
  localparam int E20 = 4;
  localparam int E21 = 5;
  localparam int E22 = 6;

  // Lanes
  localparam int LANE_X = 0;
  localparam int LANE_Y = 1;
  localparam int LANE_Z = 2;

  localparam logic signed [ENT_W-1:0] ONE_Q30      = 32'sd1073741824;
  localparam logic [CY_W-1:0]         GIMBAL_LIMIT = 31'd2048;
  localparam logic signed [ACC_W-1:0] DEG180_Q16   = 27'sd11796480;
  localparam logic signed [ACC_W-1:0] RND_HALF     = 27'sd256;
  localparam logic signed [ACC_W-1:0] DEG180_Q7W   = 27'sd23040;
  localparam logic signed [ANG_W-1:0] DEG180_Q7    = 16'sd23040;

  typedef logic signed [ENT_W-1:0] ent_t;
  typedef logic signed [XY_W-1:0]  vec_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  // atan(2^-i) in degrees, scaled by 2^16
  function automatic acc_t atan_deg(input int i);
    acc_t r;
    case (i)
      0:       r = 27'sd2949120;
      1:       r = 27'sd1740967;
      2:       r = 27'sd919879;
      3:       r = 27'sd466945;
      4:       r = 27'sd234379;
      5:       r = 27'sd117304;
      6:       r = 27'sd58666;
      7:       r = 27'sd29335;
      8:       r = 27'sd14668;
      9:       r = 27'sd7334;
      10:      r = 27'sd3667;
      11:      r = 27'sd1833;
      12:      r = 27'sd917;
      13:      r = 27'sd458;
      14:      r = 27'sd229;
      15:      r = 27'sd115;
      16:      r = 27'sd57;
      17:      r = 27'sd29;
      18:      r = 27'sd14;
      19:      r = 27'sd7;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/quaternion_to_euler_xyz_core.sv
// Quaternion to XYZ Euler angle core, fully pipelined.
// Depends on qte_pkg for widths, stage counts and the arctangent table.
//
// Usage:
//   Drive quat_x/y/z/w (signed Q2.14) and raise start for one cycle per item.
//   busy is held low: an item may be accepted in every cycle.
//   Results appear on angle_x_deg/angle_y_deg/angle_z_deg (signed Q9.7 degrees)
//   for exactly one cycle, marked by done. The receiver cannot stall; each
//   result must be taken in the cycle done is high.
// Latency and throughput:
//   One item per cycle sustained.
//   Latency is set by the one-bit-per-stage divider (31 stages), the
//   one-bit-per-stage square root (31 stages) and the 20-stage CORDIC.
// Matrix entries are formed as numerator * 2^30 / |q|^2; a zero quaternion
// gives the identity. Under gimbal lock the Z angle is forced to zero.
// An angle of -180 degrees is reported as +180.
// Reset:
//   rst clears all valid bits; items in flight are dropped and no done
//   strobe follows until a new item is accepted.
module quaternion_to_euler_xyz_core import qte_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [15:0]      quat_x,
  input  logic signed [15:0]      quat_y,
  input  logic signed [15:0]      quat_z,
  input  logic signed [15:0]      quat_w,
  output logic                    done,
  output logic signed [ANG_W-1:0] angle_x_deg,
  output logic signed [ANG_W-1:0] angle_y_deg,
  output logic signed [ANG_W-1:0] angle_z_deg
);

  logic accept;

  // Pipeline never blocks
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // ---------------------------------------------------------------------
  // Stage 1: products
  // ---------------------------------------------------------------------
  logic                    p1_vld;
  logic signed [PRD_W-1:0] p1_xx, p1_yy, p1_zz, p1_ww;
  logic signed [PRD_W-1:0] p1_xy, p1_wz, p1_yz, p1_wx, p1_xz, p1_wy;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld <= 1'b0;
    end else begin
      p1_vld <= accept;
    end
  end

  always_ff @(posedge clk) begin
    p1_xx <= quat_x * quat_x;
    p1_yy <= quat_y * quat_y;
    p1_zz <= quat_z * quat_z;
    p1_ww <= quat_w * quat_w;
    p1_xy <= quat_x * quat_y;
    p1_wz <= quat_w * quat_z;
    p1_yz <= quat_y * quat_z;
    p1_wx <= quat_w * quat_x;
    p1_xz <= quat_x * quat_z;
    p1_wy <= quat_w * quat_y;
  end

  // ---------------------------------------------------------------------
  // Stage 2: norm and matrix numerators
  // ---------------------------------------------------------------------
  logic signed [NUM_W-1:0] s_xx, s_yy, s_zz, s_ww, s_nn;
  logic signed [NUM_W-1:0] s_xy, s_wz, s_yz, s_wx, s_xz, s_wy;
  logic signed [NUM_W-1:0] num_next [NUM_ENT];

  logic                    p2_vld;
  logic [DEN_W-1:0]        p2_n;
  logic signed [NUM_W-1:0] p2_num [NUM_ENT];

  always_comb begin
    s_xx = NUM_W'(p1_xx);
    s_yy = NUM_W'(p1_yy);
    s_zz = NUM_W'(p1_zz);
    s_ww = NUM_W'(p1_ww);
    s_xy = NUM_W'(p1_xy);
    s_wz = NUM_W'(p1_wz);
    s_yz = NUM_W'(p1_yz);
    s_wx = NUM_W'(p1_wx);
    s_xz = NUM_W'(p1_xz);
    s_wy = NUM_W'(p1_wy);
    s_nn = s_xx + s_yy + s_zz + s_ww;
    num_next[E00] = s_nn - ((s_yy + s_zz) <<< 1);
    num_next[E10] = (s_xy + s_wz) <<< 1;
    num_next[E11] = s_nn - ((s_xx + s_zz) <<< 1);
    num_next[E12] = (s_yz - s_wx) <<< 1;
    num_next[E20] = (s_xz - s_wy) <<< 1;
    num_next[E21] = (s_yz + s_wx) <<< 1;
    num_next[E22] = s_nn - ((s_xx + s_yy) <<< 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_vld <= 1'b0;
    end else begin
      p2_vld <= p1_vld;
    end
  end

  always_ff @(posedge clk) begin
    p2_n   <= s_nn[DEN_W-1:0];
    p2_num <= num_next;
  end

  // ---------------------------------------------------------------------
  // Divider: one quotient bit per stage, seven entries side by side
  // ---------------------------------------------------------------------
  logic             d_vld  [DIV_STEPS+1];
  logic             d_zero [DIV_STEPS+1];
  logic [DEN_W-1:0] d_den  [DIV_STEPS+1];
  logic [REM_W-1:0] d_rem  [DIV_STEPS+1][NUM_ENT];
  logic [Q_W-1:0]   d_q    [DIV_STEPS+1][NUM_ENT];
  logic             d_neg  [DIV_STEPS+1][NUM_ENT];

  // Load: split numerators into sign and magnitude
  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld[0] <= 1'b0;
    end else begin
      d_vld[0] <= p2_vld;
    end
  end

  always_ff @(posedge clk) begin
    d_den[0]  <= p2_n;
    d_zero[0] <= (p2_n == '0);
    for (int e = 0; e < NUM_ENT; e++) begin
      d_neg[0][e] <= p2_num[e][NUM_W-1];
      d_rem[0][e] <= p2_num[e][NUM_W-1] ? REM_W'(-p2_num[e]) : REM_W'(p2_num[e]);
      d_q[0][e]   <= '0;
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        d_vld[k+1] <= 1'b0;
      end else begin
        d_vld[k+1] <= d_vld[k];
      end
    end

    always_ff @(posedge clk) begin
      d_den[k+1]  <= d_den[k];
      d_zero[k+1] <= d_zero[k];
    end

    for (genvar e = 0; e < NUM_ENT; e++) begin : g_ent
      logic [REM_W-1:0] trial;
      logic             ge;

      // Shift in a zero after the first step; compare and subtract
      always_comb begin
        trial = (k == 0) ? d_rem[k][e] : (d_rem[k][e] << 1);
        ge    = (trial >= REM_W'(d_den[k]));
      end

      always_ff @(posedge clk) begin
        d_rem[k+1][e] <= ge ? (trial - REM_W'(d_den[k])) : trial;
        d_q[k+1][e]   <= {d_q[k][e][Q_W-2:0], ge};
        d_neg[k+1][e] <= d_neg[k][e];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Apply sign, substitute identity for a zero quaternion
  // ---------------------------------------------------------------------
  logic e_vld;
  ent_t e_m [NUM_ENT];

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
    end else begin
      e_vld <= d_vld[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    for (int e = 0; e < NUM_ENT; e++) begin
      if (d_zero[DIV_STEPS]) begin
        e_m[e] <= (e == E00 || e == E11 || e == E22) ? ONE_Q30 : '0;
      end else if (d_neg[DIV_STEPS][e]) begin
        e_m[e] <= -$signed({1'b0, d_q[DIV_STEPS][e]});
      end else begin
        e_m[e] <= $signed({1'b0, d_q[DIV_STEPS][e]});
      end
    end
  end

  // ---------------------------------------------------------------------
  // Squares for the cosine term
  // ---------------------------------------------------------------------
  logic                    q_vld;
  logic signed [2*ENT_W-1:0] q_sq00, q_sq10;
  ent_t                    q_m [NUM_ENT];

  always_ff @(posedge clk) begin
    if (rst) begin
      q_vld <= 1'b0;
    end else begin
      q_vld <= e_vld;
    end
  end

  always_ff @(posedge clk) begin
    q_sq00 <= e_m[E00] * e_m[E00];
    q_sq10 <= e_m[E10] * e_m[E10];
    q_m    <= e_m;
  end

  // ---------------------------------------------------------------------
  // Square root: one root bit per stage
  // ---------------------------------------------------------------------
  logic             r_vld [SQRT_STEPS+1];
  logic [RAD_W-1:0] r_v   [SQRT_STEPS+1];
  logic [RAD_W-1:0] r_res [SQRT_STEPS+1];
  ent_t             r_m   [SQRT_STEPS+1][NUM_ENT];

  always_ff @(posedge clk) begin
    if (rst) begin
      r_vld[0] <= 1'b0;
    end else begin
      r_vld[0] <= q_vld;
    end
  end

  always_ff @(posedge clk) begin
    r_v[0]   <= RAD_W'(q_sq00) + RAD_W'(q_sq10);
    r_res[0] <= '0;
    r_m[0]   <= q_m;
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (2 * (SQRT_STEPS - 1 - k));
    logic [RAD_W-1:0] trial;
    logic             ge;

    always_comb begin
      trial = r_res[k] + BIT;
      ge    = (r_v[k] >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        r_vld[k+1] <= 1'b0;
      end else begin
        r_vld[k+1] <= r_vld[k];
      end
    end

    always_ff @(posedge clk) begin
      r_v[k+1]   <= ge ? (r_v[k] - trial) : r_v[k];
      r_res[k+1] <= ge ? ((r_res[k] >> 1) + BIT) : (r_res[k] >> 1);
      r_m[k+1]   <= r_m[k];
    end
  end

  // ---------------------------------------------------------------------
  // CORDIC load: pick operands, fold left half-plane
  // ---------------------------------------------------------------------
  logic [CY_W-1:0] cy;
  logic            lock;
  vec_t            in_y [NUM_LANES];
  vec_t            in_x [NUM_LANES];

  logic c_vld  [CORDIC_STEPS+1];
  logic c_zf   [CORDIC_STEPS+1];
  vec_t c_x    [CORDIC_STEPS+1][NUM_LANES];
  vec_t c_y    [CORDIC_STEPS+1][NUM_LANES];
  acc_t c_acc  [CORDIC_STEPS+1][NUM_LANES];
  logic c_yz   [CORDIC_STEPS+1][NUM_LANES];
  logic c_xn   [CORDIC_STEPS+1][NUM_LANES];

  always_comb begin
    cy   = r_res[SQRT_STEPS][CY_W-1:0];
    lock = (cy <= GIMBAL_LIMIT);
    in_y[LANE_X] = lock ? -XY_W'(r_m[SQRT_STEPS][E12]) : XY_W'(r_m[SQRT_STEPS][E21]);
    in_x[LANE_X] = lock ? XY_W'(r_m[SQRT_STEPS][E11]) : XY_W'(r_m[SQRT_STEPS][E22]);
    in_y[LANE_Y] = -XY_W'(r_m[SQRT_STEPS][E20]);
    in_x[LANE_Y] = $signed(XY_W'(cy));
    in_y[LANE_Z] = XY_W'(r_m[SQRT_STEPS][E10]);
    in_x[LANE_Z] = XY_W'(r_m[SQRT_STEPS][E00]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld[0] <= 1'b0;
    end else begin
      c_vld[0] <= r_vld[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    c_zf[0] <= lock;
    for (int l = 0; l < NUM_LANES; l++) begin
      c_yz[0][l] <= (in_y[l] == '0);
      c_xn[0][l] <= in_x[l][XY_W-1];
      if (in_x[l][XY_W-1]) begin
        c_x[0][l]   <= -in_x[l];
        c_y[0][l]   <= -in_y[l];
        c_acc[0][l] <= (in_y[l] > 0) ? DEG180_Q16 : -DEG180_Q16;
      end else begin
        c_x[0][l]   <= in_x[l];
        c_y[0][l]   <= in_y[l];
        c_acc[0][l] <= '0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // CORDIC vectoring: one micro-rotation per stage, three lanes
  // ---------------------------------------------------------------------
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    localparam acc_t STEP_ANG = atan_deg(i);

    always_ff @(posedge clk) begin
      if (rst) begin
        c_vld[i+1] <= 1'b0;
      end else begin
        c_vld[i+1] <= c_vld[i];
      end
    end

    always_ff @(posedge clk) begin
      c_zf[i+1] <= c_zf[i];
    end

    for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
      vec_t sx, sy;

      always_comb begin
        sx = c_x[i][l] >>> i;
        sy = c_y[i][l] >>> i;
      end

      // Rotate toward the x axis
      always_ff @(posedge clk) begin
        if (c_y[i][l] > 0) begin
          c_x[i+1][l]   <= c_x[i][l] + sy;
          c_y[i+1][l]   <= c_y[i][l] - sx;
          c_acc[i+1][l] <= c_acc[i][l] + STEP_ANG;
        end else begin
          c_x[i+1][l]   <= c_x[i][l] - sy;
          c_y[i+1][l]   <= c_y[i][l] + sx;
          c_acc[i+1][l] <= c_acc[i][l] - STEP_ANG;
        end
        c_yz[i+1][l] <= c_yz[i][l];
        c_xn[i+1][l] <= c_xn[i][l];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output: round to Q9.7, saturate, fold -180, apply special cases
  // ---------------------------------------------------------------------
  acc_t              rnd [NUM_LANES];
  logic signed [ANG_W-1:0] ang [NUM_LANES];

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      rnd[l] = (c_acc[CORDIC_STEPS][l] + RND_HALF) >>> 9;
      if (c_yz[CORDIC_STEPS][l]) begin
        ang[l] = c_xn[CORDIC_STEPS][l] ? DEG180_Q7 : '0;
      end else if (rnd[l] >= DEG180_Q7W || rnd[l] <= -DEG180_Q7W) begin
        ang[l] = DEG180_Q7;
      end else begin
        ang[l] = rnd[l][ANG_W-1:0];
      end
    end
    if (c_zf[CORDIC_STEPS]) begin
      ang[LANE_Z] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= c_vld[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    angle_x_deg <= ang[LANE_X];
    angle_y_deg <= ang[LANE_Y];
    angle_z_deg <= ang[LANE_Z];
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LATENCY))
    else $error("done without an item accepted LATENCY cycles earlier");

  a_no_minus180: assert property (@(posedge clk) disable iff (rst)
    done |-> (angle_x_deg != -DEG180_Q7 && angle_y_deg != -DEG180_Q7 &&
              angle_z_deg != -DEG180_Q7))
    else $error("angle of -180 reached the output");

  a_lock_zero_z: assert property (@(posedge clk) disable iff (rst)
    (c_vld[0] && c_zf[0]) |-> ##(CORDIC_STEPS + 1) (done && angle_z_deg == '0))
    else $error("gimbal lock item produced nonzero Z angle");

endmodule

>>> bench/qte_checker.sv
// Checker for the quaternion to XYZ Euler angle core: watches accepted items
// and done strobes, predicts angles and compares them. Depends on qte_pkg.
`timescale 1ns / 1ps
module qte_checker import qte_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic                    busy,
  input  logic signed [15:0]      quat_x,
  input  logic signed [15:0]      quat_y,
  input  logic signed [15:0]      quat_z,
  input  logic signed [15:0]      quat_w,
  input  logic                    done,
  input  logic signed [ANG_W-1:0] angle_x_deg,
  input  logic signed [ANG_W-1:0] angle_y_deg,
  input  logic signed [ANG_W-1:0] angle_z_deg,
  output int                      fail_count,
  output int                      pending,
  output int                      angles_seen,
  output int                      gimbal_seen
);

  typedef struct packed {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
  } euler_t;

  euler_t euler_q[$];

  localparam longint HALF_TURN_Q16 = 64'sd11796480;
  localparam longint HALF_TURN_Q7  = 64'sd23040;
  localparam longint LOCK_LIMIT    = 64'sd2048;

  // Rotation steps, degrees scaled by 2^16
  localparam longint STEP_DEG [0:19] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7};

  function automatic longint floor_sh(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint to_q30(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (mag <<< 30) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint root_floor(longint v);
    longint res;
    longint bitv;
    res = 0;
    bitv = 64'sd1 <<< 62;
    while (bitv > v) bitv = bitv >>> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >>> 1) + bitv;
      end else begin
        res = res >>> 1;
      end
      bitv = bitv >>> 2;
    end
    return res;
  endfunction

  // Vectoring rotation toward the x axis, angle in Q9.7 degrees
  function automatic longint arctan_deg(longint yv, longint xv);
    longint base;
    longint acc;
    longint nx;
    longint ny;
    longint r;
    base = 0;
    acc = 0;
    if (yv == 0) return (xv < 0) ? HALF_TURN_Q7 : 0;
    if (xv < 0) begin
      base = (yv > 0) ? HALF_TURN_Q16 : -HALF_TURN_Q16;
      xv = -xv;
      yv = -yv;
    end
    for (int i = 0; i < 20; i++) begin
      if (yv > 0) begin
        nx = xv + floor_sh(yv, i);
        ny = yv - floor_sh(xv, i);
        acc += STEP_DEG[i];
      end else begin
        nx = xv - floor_sh(yv, i);
        ny = yv + floor_sh(xv, i);
        acc -= STEP_DEG[i];
      end
      xv = nx;
      yv = ny;
    end
    r = floor_sh(base + acc + 256, 9);
    if (r > HALF_TURN_Q7) r = HALF_TURN_Q7;
    if (r < -HALF_TURN_Q7) r = -HALF_TURN_Q7;
    if (r == -HALF_TURN_Q7) r = HALF_TURN_Q7;
    return r;
  endfunction

  function automatic euler_t predict_euler(longint x, longint y, longint z, longint w,
                                           output bit locked);
    longint xx, yy, zz, ww, n;
    longint m00, m10, m11, m12, m20, m21, m22, cy;
    euler_t e;
    xx = x * x; yy = y * y; zz = z * z; ww = w * w;
    n = xx + yy + zz + ww;
    if (n == 0) begin
      m00 = 64'sd1 <<< 30; m11 = m00; m22 = m00;
      m10 = 0; m12 = 0; m20 = 0; m21 = 0;
    end else begin
      m00 = to_q30(n - 2 * (yy + zz), n);
      m10 = to_q30(2 * (x * y + w * z), n);
      m11 = to_q30(n - 2 * (xx + zz), n);
      m12 = to_q30(2 * (y * z - w * x), n);
      m20 = to_q30(2 * (x * z - w * y), n);
      m21 = to_q30(2 * (y * z + w * x), n);
      m22 = to_q30(n - 2 * (xx + yy), n);
    end
    cy = root_floor(m00 * m00 + m10 * m10);
    locked = (cy <= LOCK_LIMIT);
    if (!locked) begin
      e.ax = 16'(arctan_deg(m21, m22));
      e.az = 16'(arctan_deg(m10, m00));
    end else begin
      e.ax = 16'(arctan_deg(-m12, m11));
      e.az = '0;
    end
    e.ay = 16'(arctan_deg(-m20, cy));
    return e;
  endfunction

  assign pending = euler_q.size();

  // Predict on accept, compare on done
  always @(posedge clk) begin
    euler_t e;
    euler_t got;
    euler_t pred;
    bit locked;
    if (rst) begin
      euler_q.delete();
      fail_count <= 0;
      angles_seen <= 0;
      gimbal_seen <= 0;
    end else begin
      if (done) begin
        got = '{angle_x_deg, angle_y_deg, angle_z_deg};
        angles_seen <= angles_seen + 1;
        if (euler_q.size() == 0) begin
          $error("result with no item waiting: %0d %0d %0d", got.ax, got.ay, got.az);
          fail_count <= fail_count + 1;
        end else begin
          e = euler_q.pop_front();
          if (got.ax !== e.ax)
            $error("angle_x_deg expected %0d got %0d", e.ax, got.ax);
          if (got.ay !== e.ay)
            $error("angle_y_deg expected %0d got %0d", e.ay, got.ay);
          if (got.az !== e.az)
            $error("angle_z_deg expected %0d got %0d", e.az, got.az);
          if (got !== e) fail_count <= fail_count + 1;
        end
      end
      if (start && !busy) begin
        pred = predict_euler(quat_x, quat_y, quat_z, quat_w, locked);
        euler_q.insert(euler_q.size(), pred);
        if (locked) gimbal_seen <= gimbal_seen + 1;
      end
    end
  end

endmodule

>>> bench/tb_top.sv
// Top of the bench for quaternion_to_euler_xyz_core: clock, reset, stimulus
// and verdict. Depends on qte_pkg, the core and qte_checker.
`timescale 1ns / 1ps
module tb_top import qte_pkg::*;;

  logic clk, rst, start, busy, done;
  logic signed [15:0] quat_x, quat_y, quat_z, quat_w;
  logic signed [ANG_W-1:0] angle_x_deg, angle_y_deg, angle_z_deg;
  int fail_count, pending, angles_seen, gimbal_seen;
  longint cycles;

  quaternion_to_euler_xyz_core i_dut (.*);
  qte_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Bound the run
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 200000) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Hold one quaternion until accepted
  task automatic send_quat(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                           logic [15:0] w);
    start <= 1'b1;
    quat_x <= x; quat_y <= y; quat_z <= z; quat_w <= w;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic idle_burst();
    start <= 1'b0;
    repeat ($urandom_range(1, 15)) @(negedge clk);
  endtask

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'(signed'($urandom_range(0, 64)) - 32);
      3: return 16'h4000;
      4: return 16'hc000;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [15:0] a, b, c, d;
    rst = 1'b1; start = 1'b0;
    quat_x = '0; quat_y = '0; quat_z = '0; quat_w = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: zero, identity, axes, extremes, gimbal lock, half turns
    send_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_quat(16'h0000, 16'h0000, 16'h0000, 16'h4000);
    send_quat(16'h4000, 16'h0000, 16'h0000, 16'h0000);
    send_quat(16'h0000, 16'h4000, 16'h0000, 16'h0000);
    send_quat(16'h0000, 16'h0000, 16'h4000, 16'h0000);
    send_quat(16'hc000, 16'h0000, 16'h0000, 16'h0000);
    send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_quat(16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
    send_quat(16'h0000, 16'h2d41, 16'h0000, 16'h2d41);
    send_quat(16'h0000, 16'hd2bf, 16'h0000, 16'h2d41);
    send_quat(16'h1000, 16'h1000, 16'h1000, 16'h1000);
    send_quat(16'h1000, 16'hf000, 16'h1000, 16'h1000);
    send_quat(16'h0000, 16'h0000, 16'h0001, 16'h0000);
    send_quat(16'h0001, 16'h0000, 16'h0000, 16'hffff);
    send_quat(16'h0000, 16'h0000, 16'h4000, 16'hc000);
    send_quat(16'h5555, 16'haaaa, 16'h5555, 16'haaaa);

    // Random: mixed components, near-lock pairs, idle bursts early on
    for (int i = 0; i < 1900; i++) begin
      a = rand_comp(); b = rand_comp(); c = rand_comp(); d = rand_comp();
      if ($urandom_range(0, 7) == 0) begin
        c = a; d = b;
      end else if ($urandom_range(0, 7) == 0) begin
        c = -a; d = b;
      end
      send_quat(a, b, c, d);
      if (i < 1500 && $urandom_range(0, 3) == 0) idle_burst();
    end
    start <= 1'b0;

    // Drain, then allow for the pipeline depth
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Checked %0d angle triples, %0d of them under gimbal lock.",
             angles_seen, gimbal_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> quaternion_to_euler_xyz_core.f
rtl/qte_pkg.sv
rtl/quaternion_to_euler_xyz_core.sv
bench/qte_checker.sv
bench/tb_top.sv
